// ----- design/utf8d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types, constants and helpers for the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned MaxTextBytes = 65536;
  localparam int unsigned CountCapInt  =
      (MaxTextBytes - 1 < 65535) ? (MaxTextBytes - 1) : 65535;
  localparam logic [15:0] CountCap     = 16'(CountCapInt);

  localparam logic [2:0] Len1 = 3'd1;
  localparam logic [2:0] Len2 = 3'd2;
  localparam logic [2:0] Len3 = 3'd3;
  localparam logic [2:0] Len4 = 3'd4;

  typedef logic [15:0] count_t;
  typedef logic [20:0] code_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    code_t      code_point;
    count_t     start_offset;
    logic [2:0] nominal_length;
    count_t     char_index;
    count_t     utf16_offset;
    logic       last_of_text;
  } out_word_t;

  // input register contents handed to the decoder
  typedef struct packed {
    logic     valid;
    in_word_t word;
  } stage_t;

  // decoder result handed to the output register
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } result_t;

  typedef struct packed {
    code_t      partial_code;
    logic [1:0] bytes_pending;
    logic [2:0] char_length;
    count_t     char_start;
    count_t     byte_count;
    count_t     char_count;
    count_t     utf16_count;
  } dec_state_t;

  function automatic count_t sat_add(count_t a, logic [1:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {15'b0, b};
    return (s > {1'b0, CountCap}) ? CountCap : s[15:0];
  endfunction

endpackage

// ----- design/utf8d_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder channels
// Valid/ready channels for input bytes and decoded characters.
// ----------------------------------------------------------------------------
interface utf8d_in_if;
  import utf8d_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface utf8d_out_if;
  import utf8d_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// ----- design/utf8d_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder input register
// Captures one byte word per cycle and holds it until the decoder advances.
// ----------------------------------------------------------------------------
module utf8d_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  utf8d_in_if.sink          in_i,
  input  logic              advance_i,
  output utf8d_pkg::stage_t stage_o
);
  import utf8d_pkg::*;

  logic     vld_q;
  in_word_t word_q;
  logic     take;

  assign in_i.ready = !vld_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (advance_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q <= in_i.word;
    end
  end

  assign stage_o.valid = vld_q;
  assign stage_o.word  = word_q;
endmodule

// ----- design/utf8d_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder core
// Per-text decode state and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
module utf8d_decode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  utf8d_pkg::stage_t     stage_i,
  input  logic                  advance_i,
  output utf8d_pkg::result_t    result_o,
  output utf8d_pkg::dec_state_t state_o
);
  import utf8d_pkg::*;

  dec_state_t state_q;
  dec_state_t state_d;
  dec_state_t nxt;
  code_t      cont;
  logic [2:0] len;
  code_t      lead_code;
  logic [7:0] b;
  logic       eot;
  logic       emit;
  logic       fire;

  assign b    = stage_i.word.data_byte;
  assign eot  = stage_i.word.end_of_text;
  assign fire = stage_i.valid && advance_i;

  always_comb begin
    nxt       = state_q;
    cont      = '0;
    len       = Len1;
    lead_code = {13'b0, b};

    if (state_q.bytes_pending != 2'd0) begin
      // pack continuation bits below those already gathered
      case (state_q.bytes_pending)
        2'd1:    cont = {15'b0, b[5:0]};
        2'd2:    cont = {9'b0, b[5:0], 6'b0};
        default: cont = {3'b0, b[5:0], 12'b0};
      endcase
      nxt.partial_code  = state_q.partial_code | cont;
      nxt.bytes_pending = state_q.bytes_pending - 2'd1;
    end else begin
      case (b) inside
        [8'h00:8'h7F]: begin
          lead_code = {13'b0, b};
          len       = Len1;
        end
        [8'hC0:8'hDF]: begin
          lead_code = {10'b0, b[4:0], 6'b0};
          len       = Len2;
        end
        [8'hE0:8'hEF]: begin
          lead_code = {5'b0, b[3:0], 12'b0};
          len       = Len3;
        end
        [8'hF0:8'hF7]: begin
          lead_code = {b[2:0], 18'b0};
          len       = Len4;
        end
        default: begin
          lead_code = {13'b0, b};
          len       = Len1;
        end
      endcase
      nxt.char_start    = state_q.byte_count;
      nxt.partial_code  = lead_code;
      nxt.char_length   = len;
      nxt.bytes_pending = 2'(len - 3'd1);
    end
    nxt.byte_count = sat_add(state_q.byte_count, 2'd1);

    emit = (nxt.bytes_pending == 2'd0) || eot;

    result_o.valid               = stage_i.valid && emit;
    result_o.word.code_point     = nxt.partial_code;
    result_o.word.start_offset   = nxt.char_start;
    result_o.word.nominal_length = nxt.char_length;
    result_o.word.char_index     = state_q.char_count;
    result_o.word.utf16_offset   = state_q.utf16_count;
    result_o.word.last_of_text   = eot;

    state_d = nxt;
    if (emit) begin
      state_d.char_count    = sat_add(state_q.char_count, 2'd1);
      state_d.utf16_count   = sat_add(state_q.utf16_count,
                                      (nxt.partial_code[20:16] != 5'd0) ? 2'd2 : 2'd1);
      state_d.bytes_pending = 2'd0;
    end
    // clear everything once the text closes
    if (eot) begin
      state_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;
endmodule

// ----- design/utf8d_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder output register
// Holds one decoded character word and drives the pipeline advance.
// ----------------------------------------------------------------------------
module utf8d_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  utf8d_pkg::result_t result_i,
  utf8d_out_if.source        out_o,
  output logic               advance_o
);
  import utf8d_pkg::*;

  logic      vld_q;
  out_word_t word_q;

  // advance when the register is empty or its word leaves this cycle
  assign advance_o = !vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (advance_o) begin
      vld_q <= result_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && result_i.valid) begin
      word_q <= result_i.word;
    end
  end

  assign out_o.valid = vld_q;
  assign out_o.word  = word_q;
endmodule

// ----- design/utf8_code_point_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 code point decoder
// Decodes a UTF-8 byte stream into code points with byte, character and
// UTF-16 positions.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  in_i    | in  | data_byte[7:0], end_of_text
//  out_o   | out | code_point[20:0], start_offset, nominal_length[2:0],
//          |     | char_index, utf16_offset, last_of_text
//
//  One byte per cycle unless the output stalls; a character word is offered
//  after its final byte passes the input register, decode and output register.
//  Reset clears the decode state and the valid flags of both registers;
//  counters also clear after each end-of-text byte.
//  A stalled output holds its word; an empty input register still takes one
//  more byte while a result waits.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  utf8d_in_if.sink    in_i,
  utf8d_out_if.source out_o
);
  import utf8d_pkg::*;

  stage_t     stage;
  result_t    result;
  dec_state_t state;
  logic       advance;

  utf8d_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  utf8d_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .advance_i (advance),
    .result_o  (result),
    .state_o   (state)
  );

  utf8d_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .result_i  (result),
    .out_o     (out_o),
    .advance_o (advance)
  );

  // a pending continuation count always fits the open character's length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state.bytes_pending != 2'd0 |->
      ({1'b0, state.bytes_pending} < state.char_length))
    else $error("pending continuations exceed character length");

  // end of text leaves all counters cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage.valid && advance && stage.word.end_of_text) |=>
      (state.byte_count == 16'd0 && state.char_count == 16'd0 &&
       state.utf16_count == 16'd0 && state.bytes_pending == 2'd0))
    else $error("state not cleared after end of text");

  // two-byte characters cannot reach past 0x7FF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.word.nominal_length == Len2) |->
      (out_o.word.code_point[20:11] == 10'd0))
    else $error("two-byte code point out of range");

  // a result is produced only for a word taken from the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result.valid |-> stage.valid)
    else $error("result without input word");
endmodule
